>>> design/rth_pkg.sv
// rth_pkg: widths, register indexes, reset values and defaults for the
// residue transition histogram
// no dependencies; used by residue_transition_histogram, rth_histogram_check and the testbench
package rth_pkg;

    // stream field widths
    localparam int NUM_W  = 32;   // fed number
    localparam int IDX_W  = 4;    // read_row / read_column
    localparam int OUT_W  = 32;   // cell_count / largest_count on the port
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 64;

    // configuration register widths
    localparam int BASE_W     = 5;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_START    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_STEP  = 3'd4;

    // configuration reset values
    localparam logic [BASE_W-1:0] BASE_RST  = 5'd10;
    localparam logic [STEP_W-1:0] START_RST = 4'd0;
    localparam logic [STEP_W-1:0] STEP_RST  = 4'd1;

    // smallest meaningful base
    localparam int BASE_MIN = 2;

    // operation codes
    localparam logic OP_FEED = 1'b0;
    localparam logic OP_READ = 1'b1;

    // parameter defaults
    localparam int MAX_BASE_DEF   = 16;
    localparam int COUNT_BITS_DEF = 32;

endpackage

>>> design/residue_transition_histogram.sv
// residue_transition_histogram: counts digit-to-digit transitions of a number
// stream in a MAX_BASE x MAX_BASE matrix of saturating counters
// depends on rth_pkg
//
// channel   dir   handshake              payload
// s_*       in    s_tvalid / s_tready    s_tdata: number, read_row, read_column
//                                        s_tuser: op
// m_*       out   m_tvalid / m_tready    m_tdata: cell_count, largest_count
//                                        m_tuser: was_counted
// cfg_*     in    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a feed forms the remainder by the base one bit of the number per cycle,
// then row and column indexes come from two bit-serial dividers, then one
// memory read-modify-write. a read of a cell goes straight to the memory
// read, or to the result when its row or column is out of range.
// after reset a clearing pass writes zero to all MAX_BASE*MAX_BASE cells, one
// per cycle, before the first item is taken; configuration is always taken.
// a finished result waits in the output register while the next item runs.
module residue_transition_histogram #(
    parameter int MAX_BASE   = rth_pkg::MAX_BASE_DEF,
    parameter int COUNT_BITS = rth_pkg::COUNT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rth_pkg::IN_TDATA_W-1:0]     s_tdata,   // number, read_row, read_column
    input  logic                               s_tuser,   // op
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rth_pkg::OUT_TDATA_W-1:0]    m_tdata,   // cell_count, largest_count
    output logic                               m_tuser,   // was_counted
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rth_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rth_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NUM_W   = rth_pkg::NUM_W;
    localparam int IDX_W   = rth_pkg::IDX_W;
    localparam int OUT_W   = rth_pkg::OUT_W;
    localparam int BASE_W  = rth_pkg::BASE_W;
    localparam int STEP_W  = rth_pkg::STEP_W;
    localparam int CELLS   = MAX_BASE * MAX_BASE;
    localparam int ADDR_W  = $clog2(CELLS);
    // digits stay below the base, which never exceeds 31
    localparam int DIG_LIM = (MAX_BASE < 32) ? MAX_BASE : 32;
    localparam int DIG_W   = $clog2(DIG_LIM);
    localparam int DW      = (DIG_W > STEP_W) ? DIG_W : STEP_W;
    localparam int CNT_W   = $clog2(NUM_W);
    localparam int DCNT_W  = $clog2(DW);

    // state codes
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_CHK   = 3'd4;
    localparam logic [2:0] ST_RD    = 3'd5;
    localparam logic [2:0] ST_UPD   = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    // count memory
    logic [COUNT_BITS-1:0] mem [CELLS];
    logic [COUNT_BITS-1:0] mem_q;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;

    // control and datapath registers
    logic [2:0]            state_reg, state_next;
    logic [ADDR_W-1:0]     clr_addr_reg, clr_addr_next;
    logic [NUM_W-1:0]      num_reg, num_next;
    logic [CNT_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [DIG_W-1:0]      rem_reg, rem_next;
    logic                  op_reg, op_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [DIG_W-1:0]      prev_reg, prev_next;
    logic                  prev_valid_reg, prev_valid_next;
    logic [DW-1:0]         rnum_reg, rnum_next, cnum_reg, cnum_next;
    logic [STEP_W-1:0]     rrem_reg, rrem_next, crem_reg, crem_next;
    logic [DW-1:0]         rquo_reg, rquo_next, cquo_reg, cquo_next;
    logic                  row_ge_reg, row_ge_next, col_ge_reg, col_ge_next;
    logic [DCNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic [COUNT_BITS-1:0] max_reg, max_next;
    logic [COUNT_BITS-1:0] res_cell_reg, res_cell_next;
    logic                  res_hit_reg, res_hit_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]      m_cell_reg, m_cell_next;
    logic [OUT_W-1:0]      m_max_reg, m_max_next;
    logic                  m_hit_reg, m_hit_next;

    // configuration registers
    logic [BASE_W-1:0]     base_reg;
    logic [STEP_W-1:0]     row_start_reg, row_step_reg;
    logic [STEP_W-1:0]     col_start_reg, col_step_reg;

    // combinational helpers
    logic [DIG_W:0]        base_eff;
    logic [STEP_W-1:0]     rstep_eff, cstep_eff;
    logic [DIG_W:0]        mod_shift;
    logic [DIG_W-1:0]      mod_rem;
    logic [STEP_W:0]       rdiv_shift, cdiv_shift;
    logic                  rdiv_bit, cdiv_bit;
    logic                  cell_hit;
    logic [COUNT_BITS-1:0] cell_inc;
    logic                  out_free;
    logic                  in_acc;
    logic [NUM_W-1:0]      in_number;
    logic [IDX_W-1:0]      in_row, in_col;

    assign in_number = s_tdata[NUM_W-1:0];
    assign in_row    = s_tdata[NUM_W+IDX_W-1:NUM_W];
    assign in_col    = s_tdata[NUM_W+2*IDX_W-1:NUM_W+IDX_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {m_max_reg, m_cell_reg};
    assign m_tuser   = m_hit_reg;
    assign out_free  = !m_valid_reg || m_tready;

    // effective base and steps
    always_comb
    begin
        if (int'(base_reg) < rth_pkg::BASE_MIN)
            base_eff = (DIG_W+1)'(rth_pkg::BASE_MIN);
        else if (int'(base_reg) > MAX_BASE)
            base_eff = (DIG_W+1)'(MAX_BASE);
        else
            base_eff = (DIG_W+1)'(base_reg);
        rstep_eff = (row_step_reg == '0) ? STEP_W'(1) : row_step_reg;
        cstep_eff = (col_step_reg == '0) ? STEP_W'(1) : col_step_reg;
    end

    // one bit of the remainder by the base
    always_comb
    begin
        mod_shift = {rem_reg, num_reg[NUM_W-1]};
        if (mod_shift >= base_eff)
            mod_rem = DIG_W'(mod_shift - base_eff);
        else
            mod_rem = DIG_W'(mod_shift);
    end

    // one quotient bit of the row and column dividers
    always_comb
    begin
        rdiv_shift = {rrem_reg, rnum_reg[DW-1]};
        cdiv_shift = {crem_reg, cnum_reg[DW-1]};
        rdiv_bit   = (rdiv_shift >= {1'b0, rstep_eff});
        cdiv_bit   = (cdiv_shift >= {1'b0, cstep_eff});
    end

    // pair lands on a matrix cell
    assign cell_hit = row_ge_reg && col_ge_reg && (rrem_reg == '0) && (crem_reg == '0)
                      && (int'(rquo_reg) < MAX_BASE) && (int'(cquo_reg) < MAX_BASE);

    // saturating increment
    assign cell_inc = (mem_q == '1) ? mem_q : mem_q + COUNT_BITS'(1);

    // sequencer and datapath
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        num_next        = num_reg;
        bit_cnt_next    = bit_cnt_reg;
        rem_next        = rem_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        rnum_next       = rnum_reg;
        cnum_next       = cnum_reg;
        rrem_next       = rrem_reg;
        crem_next       = crem_reg;
        rquo_next       = rquo_reg;
        cquo_next       = cquo_reg;
        row_ge_next     = row_ge_reg;
        col_ge_next     = col_ge_reg;
        div_cnt_next    = div_cnt_reg;
        max_next        = max_reg;
        res_cell_next   = res_cell_reg;
        res_hit_next    = res_hit_reg;
        m_valid_next    = m_valid_reg;
        m_cell_next     = m_cell_reg;
        m_max_next      = m_max_reg;
        m_hit_next      = m_hit_reg;
        mem_we          = 1'b0;
        mem_waddr       = addr_reg;
        mem_wdata       = cell_inc;

        // result taken downstream
        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(CELLS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    op_next       = s_tuser;
                    res_cell_next = '0;
                    res_hit_next  = 1'b0;
                    if (s_tuser == rth_pkg::OP_READ)
                    begin
                        addr_next = ADDR_W'(in_row) * ADDR_W'(MAX_BASE) + ADDR_W'(in_col);
                        if (int'(in_row) < MAX_BASE && int'(in_col) < MAX_BASE)
                            state_next = ST_RD;
                        else
                            state_next = ST_DONE;
                    end
                    else
                    begin
                        num_next     = in_number;
                        rem_next     = '0;
                        bit_cnt_next = CNT_W'(NUM_W - 1);
                        state_next   = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                rem_next     = mod_rem;
                num_next     = {num_reg[NUM_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - CNT_W'(1);
                if (bit_cnt_reg == '0)
                begin
                    // digit done: set up the index dividers
                    row_ge_next     = prev_valid_reg && (DW'(prev_reg) >= DW'(row_start_reg));
                    col_ge_next     = DW'(mod_rem) >= DW'(col_start_reg);
                    rnum_next       = DW'(prev_reg) - DW'(row_start_reg);
                    cnum_next       = DW'(mod_rem) - DW'(col_start_reg);
                    rrem_next       = '0;
                    crem_next       = '0;
                    rquo_next       = '0;
                    cquo_next       = '0;
                    prev_next       = mod_rem;
                    prev_valid_next = 1'b1;
                    div_cnt_next    = DCNT_W'(DW - 1);
                    state_next      = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rrem_next = rdiv_bit ? STEP_W'(rdiv_shift - {1'b0, rstep_eff})
                                     : STEP_W'(rdiv_shift);
                crem_next = cdiv_bit ? STEP_W'(cdiv_shift - {1'b0, cstep_eff})
                                     : STEP_W'(cdiv_shift);
                rquo_next = {rquo_reg[DW-2:0], rdiv_bit};
                cquo_next = {cquo_reg[DW-2:0], cdiv_bit};
                rnum_next = {rnum_reg[DW-2:0], 1'b0};
                cnum_next = {cnum_reg[DW-2:0], 1'b0};
                div_cnt_next = div_cnt_reg - DCNT_W'(1);
                if (div_cnt_reg == '0)
                    state_next = ST_CHK;
            end
            ST_CHK:
            begin
                addr_next = ADDR_W'(rquo_reg) * ADDR_W'(MAX_BASE) + ADDR_W'(cquo_reg);
                if (cell_hit)
                    state_next = ST_RD;
                else
                    state_next = ST_DONE;
            end
            ST_RD:
            begin
                // memory read data arrives next cycle
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (op_reg == rth_pkg::OP_READ)
                    res_cell_next = mem_q;
                else
                begin
                    mem_we        = 1'b1;
                    res_cell_next = cell_inc;
                    res_hit_next  = 1'b1;
                    if (cell_inc > max_reg)
                        max_next = cell_inc;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_cell_next  = OUT_W'(res_cell_reg);
                    m_max_next   = OUT_W'(max_reg);
                    m_hit_next   = res_hit_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // count memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_q <= mem[addr_reg];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
            max_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            prev_reg       <= prev_next;
            prev_valid_reg <= prev_valid_next;
            max_reg        <= max_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        bit_cnt_reg  <= bit_cnt_next;
        rem_reg      <= rem_next;
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        rnum_reg     <= rnum_next;
        cnum_reg     <= cnum_next;
        rrem_reg     <= rrem_next;
        crem_reg     <= crem_next;
        rquo_reg     <= rquo_next;
        cquo_reg     <= cquo_next;
        row_ge_reg   <= row_ge_next;
        col_ge_reg   <= col_ge_next;
        div_cnt_reg  <= div_cnt_next;
        res_cell_reg <= res_cell_next;
        res_hit_reg  <= res_hit_next;
        m_cell_reg   <= m_cell_next;
        m_max_reg    <= m_max_next;
        m_hit_reg    <= m_hit_next;
    end

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= rth_pkg::BASE_RST;
            row_start_reg <= rth_pkg::START_RST;
            row_step_reg  <= rth_pkg::STEP_RST;
            col_start_reg <= rth_pkg::START_RST;
            col_step_reg  <= rth_pkg::STEP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rth_pkg::CFG_NUMBER_BASE:  base_reg      <= cfg_data;
                rth_pkg::CFG_ROW_START:    row_start_reg <= cfg_data[STEP_W-1:0];
                rth_pkg::CFG_ROW_STEP:     row_step_reg  <= cfg_data[STEP_W-1:0];
                rth_pkg::CFG_COLUMN_START: col_start_reg <= cfg_data[STEP_W-1:0];
                rth_pkg::CFG_COLUMN_STEP:  col_step_reg  <= cfg_data[STEP_W-1:0];
                default:
                begin
                    // unmapped index: write is dropped
                end
            endcase
        end
    end

endmodule

>>> test/rth_histogram_check.sv
// rth_histogram_check: watches the stream and configuration channels of the
// residue transition histogram, predicts every result and compares it
// depends on rth_pkg; instantiated beside the block by the testbench top
module rth_histogram_check (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [rth_pkg::IN_TDATA_W-1:0]  s_tdata,   // number, read_row, read_column
    input  logic                            s_tuser,   // op
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [rth_pkg::OUT_TDATA_W-1:0] m_tdata,   // cell_count, largest_count
    input  logic                            m_tuser,   // was_counted
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [rth_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rth_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatch_count,
    output int                              pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_W    = rth_pkg::NUM_W;
    localparam int IDX_W    = rth_pkg::IDX_W;
    localparam int OUT_W    = rth_pkg::OUT_W;
    localparam int BASE_W   = rth_pkg::BASE_W;
    localparam int STEP_W   = rth_pkg::STEP_W;
    localparam int MAX_BASE = rth_pkg::MAX_BASE_DEF;
    localparam int CELLS    = MAX_BASE * MAX_BASE;

    typedef struct packed {
        logic [OUT_W-1:0] cell_count;
        logic [OUT_W-1:0] largest_count;
        logic             was_counted;
    } tally_t;

    // predicted configuration
    logic [BASE_W-1:0] base_reg;
    logic [STEP_W-1:0] row_start_reg;
    logic [STEP_W-1:0] row_step_reg;
    logic [STEP_W-1:0] col_start_reg;
    logic [STEP_W-1:0] col_step_reg;

    // predicted histogram state
    logic [OUT_W-1:0]  transition_counts [0:CELLS-1];
    logic [IDX_W-1:0]  prev_digit;
    logic              prev_valid;
    logic [OUT_W-1:0]  peak_count;

    tally_t            expected_tallies [$];

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                   input logic [OUT_W-1:0] want);
        $display("%0t rth_histogram_check: %s got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // applies one accepted item to the predicted state, returns its result
    function automatic tally_t advance_histogram(input logic op,
                                                 input logic [NUM_W-1:0] number,
                                                 input logic [IDX_W-1:0] rrow,
                                                 input logic [IDX_W-1:0] rcol);
        tally_t      t;
        int unsigned base;
        int unsigned rs;
        int unsigned cs;
        int unsigned digit;
        int unsigned pd;
        int unsigned rst0;
        int unsigned cst0;
        int unsigned r;
        int unsigned c;
        t = '0;
        if (op == rth_pkg::OP_READ)
        begin
            t.cell_count = transition_counts[rrow * MAX_BASE + rcol];
        end
        else
        begin
            // out-of-range base and zero steps are clamped
            base = base_reg;
            if (base < rth_pkg::BASE_MIN)
                base = rth_pkg::BASE_MIN;
            else if (base > MAX_BASE)
                base = MAX_BASE;
            rs    = (row_step_reg == 0) ? 1 : row_step_reg;
            cs    = (col_step_reg == 0) ? 1 : col_step_reg;
            digit = number % base;
            pd    = prev_digit;
            rst0  = row_start_reg;
            cst0  = col_start_reg;
            // count the pair only when both digits sit on their grids
            if (prev_valid && pd >= rst0 && digit >= cst0 &&
                (pd - rst0) % rs == 0 && (digit - cst0) % cs == 0)
            begin
                r = (pd - rst0) / rs;
                c = (digit - cst0) / cs;
                if (r < MAX_BASE && c < MAX_BASE)
                begin
                    if (transition_counts[r * MAX_BASE + c] != '1)
                        transition_counts[r * MAX_BASE + c]++;
                    t.cell_count  = transition_counts[r * MAX_BASE + c];
                    t.was_counted = 1'b1;
                    if (t.cell_count > peak_count)
                        peak_count = t.cell_count;
                end
            end
            prev_digit = digit[IDX_W-1:0];
            prev_valid = 1'b1;
        end
        t.largest_count = peak_count;
        return t;
    endfunction

    // transaction monitor: results are compared before new items are queued
    always @(posedge clk or negedge rst_n)
    begin
        tally_t want;
        tally_t fresh;
        if (!rst_n)
        begin
            base_reg      = rth_pkg::BASE_RST;
            row_start_reg = rth_pkg::START_RST;
            row_step_reg  = rth_pkg::STEP_RST;
            col_start_reg = rth_pkg::START_RST;
            col_step_reg  = rth_pkg::STEP_RST;
            for (int i = 0; i < CELLS; i++)
                transition_counts[i] = '0;
            prev_digit = '0;
            prev_valid = 1'b0;
            peak_count = '0;
            expected_tallies.delete();
            mismatch_count  = 0;
            pending_results = 0;
        end
        else
        begin
            // configuration write
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rth_pkg::CFG_NUMBER_BASE:  base_reg      = cfg_data[BASE_W-1:0];
                    rth_pkg::CFG_ROW_START:    row_start_reg = cfg_data[STEP_W-1:0];
                    rth_pkg::CFG_ROW_STEP:     row_step_reg  = cfg_data[STEP_W-1:0];
                    rth_pkg::CFG_COLUMN_START: col_start_reg = cfg_data[STEP_W-1:0];
                    rth_pkg::CFG_COLUMN_STEP:  col_step_reg  = cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            // result transaction
            if (m_tvalid && m_tready)
            begin
                if (expected_tallies.size() == 0)
                begin
                    report_mismatch("result with nothing expected, cell_count",
                                    m_tdata[OUT_W-1:0], '0);
                end
                else
                begin
                    want = expected_tallies.pop_front();
                    if (m_tdata[OUT_W-1:0] !== want.cell_count)
                        report_mismatch("cell_count", m_tdata[OUT_W-1:0], want.cell_count);
                    if (m_tdata[2*OUT_W-1:OUT_W] !== want.largest_count)
                        report_mismatch("largest_count", m_tdata[2*OUT_W-1:OUT_W],
                                        want.largest_count);
                    if (m_tuser !== want.was_counted)
                        report_mismatch("was_counted", OUT_W'(m_tuser),
                                        OUT_W'(want.was_counted));
                end
            end
            // input transaction
            if (s_tvalid && s_tready)
            begin
                fresh = advance_histogram(s_tuser, s_tdata[NUM_W-1:0],
                                          s_tdata[NUM_W+IDX_W-1:NUM_W],
                                          s_tdata[NUM_W+2*IDX_W-1:NUM_W+IDX_W]);
                expected_tallies.insert(expected_tallies.size(), fresh);
            end
            pending_results = expected_tallies.size();
        end
    end

endmodule

>>> test/tb_residue_transition_histogram.sv
// tb_residue_transition_histogram: drives numbers, cell reads and register
// writes into the residue transition histogram with random idling
// depends on rth_pkg, residue_transition_histogram and rth_histogram_check
module tb_residue_transition_histogram;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_W       = rth_pkg::NUM_W;
    localparam int IDX_W       = rth_pkg::IDX_W;
    localparam int IN_TDATA_W  = rth_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = rth_pkg::OUT_TDATA_W;
    localparam int CFG_IDX_W   = rth_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = rth_pkg::CFG_DATA_W;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int TAIL_CYCLES   = 60;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_ITEMS   = 105;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // number, read_row, read_column
    logic                   s_tuser;   // op
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // cell_count, largest_count
    logic                   m_tuser;   // was_counted
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int mismatch_count;
    int pending_results;
    bit steady_phase;

    residue_transition_histogram dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rth_histogram_check u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= LIMIT_CYCLES)
            begin
                $display("tb_residue_transition_histogram: FAIL");
                $finish;
            end
        end
    end

    // result sink with random stalls
    initial
    begin : result_sink
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = steady_phase ? 0 : $urandom_range(0, 6);
            repeat (stall)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    // one input transaction after a random gap
    task automatic send_item(input logic op, input logic [NUM_W-1:0] number,
                             input logic [IDX_W-1:0] rrow, input logic [IDX_W-1:0] rcol);
        int gap;
        gap = steady_phase ? 0 : $urandom_range(0, 6);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {rcol, rrow, number};
        do @(posedge clk); while (!(s_tvalid && s_tready));
    endtask

    // stop feeding and wait until every result is back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(input logic [CFG_DATA_W-1:0] base, input logic [CFG_DATA_W-1:0] rs0,
                            input logic [CFG_DATA_W-1:0] rstep, input logic [CFG_DATA_W-1:0] cs0,
                            input logic [CFG_DATA_W-1:0] cstep);
        drain_results();
        write_reg(rth_pkg::CFG_NUMBER_BASE, base);
        write_reg(rth_pkg::CFG_ROW_START, rs0);
        write_reg(rth_pkg::CFG_ROW_STEP, rstep);
        write_reg(rth_pkg::CFG_COLUMN_START, cs0);
        write_reg(rth_pkg::CFG_COLUMN_STEP, cstep);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_base();
        logic [CFG_DATA_W-1:0] extremes [6] = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31};
        if ($urandom_range(0, 9) < 3)
            return extremes[$urandom_range(0, 5)];
        return CFG_DATA_W'($urandom_range(2, 16));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_start();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7)
            return CFG_DATA_W'($urandom_range(0, 3));
        if (k < 8)
            return CFG_DATA_W'(15);
        return CFG_DATA_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_step();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6)
            return CFG_DATA_W'(1);
        if (k < 8)
            return CFG_DATA_W'($urandom_range(0, 3));
        return CFG_DATA_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [NUM_W-1:0] pick_number();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6)
            return NUM_W'($urandom);
        if (k < 8)
            return NUM_W'($urandom_range(0, 63));
        return 32'hFFFF_FFF0 | NUM_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        if ($urandom_range(0, 1) == 0)
            return IDX_W'($urandom_range(0, 3));
        return IDX_W'($urandom_range(0, 15));
    endfunction

    // stimulus and verdict
    initial
    begin : stimulus
        steady_phase = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = rth_pkg::OP_FEED;
        cfg_valid = 1'b0;
        cfg_index = rth_pkg::CFG_NUMBER_BASE;
        cfg_data  = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // reset grid, base ten: first feed has no previous digit
        send_item(rth_pkg::OP_FEED, 32'd0, 4'd0, 4'd0);
        send_item(rth_pkg::OP_FEED, 32'hFFFF_FFFF, 4'd15, 4'd15);
        send_item(rth_pkg::OP_FEED, 32'd10, 4'd0, 4'd0);
        send_item(rth_pkg::OP_FEED, 32'd20, 4'd0, 4'd0);
        send_item(rth_pkg::OP_FEED, 32'd30, 4'd0, 4'd0);
        send_item(rth_pkg::OP_FEED, 32'h8000_0000, 4'd0, 4'd0);
        send_item(rth_pkg::OP_READ, 32'd0, 4'd0, 4'd0);
        send_item(rth_pkg::OP_READ, 32'hFFFF_FFFF, 4'd15, 4'd15);
        send_item(rth_pkg::OP_READ, 32'd0, 4'd0, 4'd5);
        send_item(rth_pkg::OP_READ, 32'd0, 4'd5, 4'd0);

        // base below two acts as two, zero steps act as one
        set_grid(5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
        send_item(rth_pkg::OP_FEED, 32'd1, 4'd0, 4'd0);
        send_item(rth_pkg::OP_FEED, 32'd3, 4'd0, 4'd0);
        send_item(rth_pkg::OP_FEED, 32'd0, 4'd0, 4'd0);
        send_item(rth_pkg::OP_FEED, 32'hFFFF_FFFF, 4'd0, 4'd0);
        send_item(rth_pkg::OP_READ, 32'd0, 4'd0, 4'd1);
        send_item(rth_pkg::OP_READ, 32'd0, 4'd1, 4'd1);
        send_item(rth_pkg::OP_READ, 32'd0, 4'd0, 4'd0);

        // base above maximum acts as sixteen, grid only at digit fifteen
        set_grid(5'd31, 5'd15, 5'd15, 5'd15, 5'd15);
        send_item(rth_pkg::OP_FEED, 32'd15, 4'd0, 4'd0);
        send_item(rth_pkg::OP_FEED, 32'd31, 4'd0, 4'd0);
        send_item(rth_pkg::OP_FEED, 32'hFFFF_FFFF, 4'd0, 4'd0);
        send_item(rth_pkg::OP_FEED, 32'd14, 4'd0, 4'd0);
        send_item(rth_pkg::OP_FEED, 32'd47, 4'd0, 4'd0);
        send_item(rth_pkg::OP_READ, 32'd0, 4'd0, 4'd0);
        send_item(rth_pkg::OP_READ, 32'd0, 4'd0, 4'd1);

        // random phases; counts and previous digit carry across grid changes
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_grid(pick_base(), pick_start(), pick_step(), pick_start(), pick_step());
            steady_phase = (p % 4 == 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_item(rth_pkg::OP_READ, NUM_W'($urandom), pick_index(), pick_index());
                else
                    send_item(rth_pkg::OP_FEED, pick_number(), IDX_W'($urandom_range(0, 15)),
                              IDX_W'($urandom_range(0, 15)));
            end
            steady_phase = 1'b0;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("tb_residue_transition_histogram: PASS");
        else
            $display("tb_residue_transition_histogram: FAIL");
        $finish;
    end

endmodule
